// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the neighbor degree block.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`endif

// ----- src/frnd_pkg.sv -----
`timescale 1ns / 1ps
// Package of the neighbor degree block: sizes, sequencer states, shared types.
// Depends on nothing.
package frnd_pkg;
    localparam int MaxPoints = 64;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);
    localparam int CoordW = 11;
    localparam int DegW = 6;
    localparam int LinkW = 11;
    localparam int SqW = 2 * CoordW + 1;
    localparam logic [CoordW-1:0] RangeReset = 11'd30;

    typedef enum logic [9:0] {
        ST_LOAD  = 10'b0000000001,
        ST_SORTI = 10'b0000000010,
        ST_SORTC = 10'b0000000100,
        ST_SORTK = 10'b0000001000,
        ST_SWPI  = 10'b0000010000,
        ST_SWPJ  = 10'b0000100000,
        ST_DIST  = 10'b0001000000,
        ST_SWPL  = 10'b0010000000,
        ST_OUTR  = 10'b0100000000,
        ST_OUTV  = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic [CoordW-1:0] a;
        logic [CoordW-1:0] b;
    } diff_req_t;
endpackage

// ----- src/frnd_sqdist.sv -----
`timescale 1ns / 1ps
// Shared distance unit: one registered square and sum of two coordinate gaps.
// Depends on frnd_pkg.
module frnd_sqdist import frnd_pkg::*; (
    input  logic              aclk,
    input  logic [CoordW-1:0] dx,
    input  logic [CoordW-1:0] dy,
    output logic [SqW-1:0]    dist_sq
);
    logic [SqW-1:0] dist_sq_reg;

    always_ff @(posedge aclk) begin
        dist_sq_reg <= SqW'(dx) * SqW'(dx) + SqW'(dy) * SqW'(dy);
    end

    assign dist_sq = dist_sq_reg;
endmodule

// ----- src/fixed_radius_neighbor_degrees.sv -----
`timescale 1ns / 1ps
// Top level of the neighbor degree block: point store, sort, sweep, result stream.
// Depends on frnd_pkg, frnd_sqdist and assert_macros.svh.
//
//   channel | ports                         | role
//   s_      | pos_x, pos_y, last_point      | one point per beat
//   m_      | sorted_x ... last_result      | one sorted point per beat
//   apb     | psel .. prdata                | radius register at address 0
//
// Points may be taken back to back while s_ready is high.
// Sorting is an insertion sort on x: each key is read, then larger points are shifted up past it.
// Each sweep row examines pairs until the x gap exceeds the range or the points run out.
// Each result beat is held while m_ready is low.
// The store has a single registered read port, and the distance unit is shared.
// Reset is synchronous; s_ready is low from the last point until the final beat.
`include "assert_macros.svh"
module fixed_radius_neighbor_degrees import frnd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CoordW-1:0] s_pos_x,
    input  logic [CoordW-1:0] s_pos_y,
    input  logic              s_last_point,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CoordW-1:0] m_sorted_x,
    output logic [CoordW-1:0] m_sorted_y,
    output logic [DegW-1:0]   m_point_degree,
    output logic [LinkW-1:0]  m_link_total,
    output logic [DegW-1:0]   m_max_degree,
    output logic              m_overflowed,
    output logic              m_last_result
);
    logic [CoordW-1:0] range_reg;
    state_t            state_reg;
    logic [CoordW-1:0] xs [MaxPoints];
    logic [CoordW-1:0] ys [MaxPoints];
    logic [DegW-1:0]   degs [MaxPoints];
    logic [CntW-1:0]   count_reg;
    logic              ovf_reg;
    logic [LinkW-1:0]  link_reg;
    logic [DegW-1:0]   dmax_reg;
    logic [CntW-1:0]   i_reg;
    logic [CntW-1:0]   j_reg;
    logic [CoordW-1:0] kx_reg, ky_reg;
    logic [CoordW-1:0] xi_reg, yi_reg;
    logic [DegW-1:0]   di_reg;
    logic [IdxW-1:0]   rd_addr;
    logic [CoordW-1:0] rd_x_reg, rd_y_reg;
    logic [DegW-1:0]   deg_rd_reg;
    logic [CoordW-1:0] dx, dy;
    logic [SqW-1:0]    dist_sq;
    logic [SqW-1:0]    r2;
    logic              wr_cfg;
    logic              take;
    diff_req_t         dreq;

    assign pready = 1'b1;
    assign prdata = {{(32-CoordW){1'b0}}, range_reg};
    assign wr_cfg = psel && penable && pwrite && (paddr == 2'd0);
    assign s_ready = (state_reg == ST_LOAD);
    assign take = s_valid && s_ready;
    assign r2 = SqW'(range_reg) * SqW'(range_reg);

    assign dreq.a = rd_x_reg;
    assign dreq.b = xi_reg;
    assign dx = dreq.a - dreq.b;
    assign dy = (yi_reg >= rd_y_reg) ? yi_reg - rd_y_reg : rd_y_reg - yi_reg;

    frnd_sqdist u_sq (.aclk(aclk), .dx(dx), .dy(dy), .dist_sq(dist_sq));

    always_comb begin
        unique case (state_reg)
            ST_SORTK: rd_addr = i_reg[IdxW-1:0] - 1'b1;
            ST_SORTC: rd_addr = j_reg[IdxW-1:0] - IdxW'(2);
            ST_SWPL:  rd_addr = i_reg[IdxW-1:0] + 1'b1;
            ST_SWPJ:  rd_addr = j_reg[IdxW-1:0];
            ST_DIST:  rd_addr = j_reg[IdxW-1:0] + 1'b1;
            default:  rd_addr = i_reg[IdxW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_x_reg   <= xs[rd_addr];
        rd_y_reg   <= ys[rd_addr];
        deg_rd_reg <= degs[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RangeReset;
        end else if (wr_cfg) begin
            range_reg <= pwdata[CoordW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            link_reg  <= '0;
            dmax_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            m_valid   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (take) begin
                        if (count_reg < CntW'(MaxPoints)) begin
                            xs[count_reg[IdxW-1:0]]   <= s_pos_x;
                            ys[count_reg[IdxW-1:0]]   <= s_pos_y;
                            degs[count_reg[IdxW-1:0]] <= '0;
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_last_point) begin
                            i_reg     <= CntW'(1);
                            state_reg <= ST_SORTI;
                        end
                    end
                end
                ST_SORTI: begin
                    if (i_reg >= count_reg) begin
                        link_reg  <= '0;
                        dmax_reg  <= '0;
                        i_reg     <= '0;
                        state_reg <= ST_SWPI;
                    end else begin
                        state_reg <= ST_SORTK;
                    end
                end
                ST_SORTK: begin
                    kx_reg    <= rd_x_reg;
                    ky_reg    <= rd_y_reg;
                    j_reg     <= i_reg;
                    state_reg <= ST_SORTC;
                end
                ST_SORTC: begin
                    if (j_reg != '0 && rd_x_reg > kx_reg) begin
                        xs[j_reg[IdxW-1:0]] <= rd_x_reg;
                        ys[j_reg[IdxW-1:0]] <= rd_y_reg;
                        j_reg <= j_reg - 1'b1;
                    end else begin
                        xs[j_reg[IdxW-1:0]] <= kx_reg;
                        ys[j_reg[IdxW-1:0]] <= ky_reg;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SORTI;
                    end
                end
                ST_SWPI: begin
                    if (i_reg >= count_reg) begin
                        i_reg     <= '0;
                        state_reg <= ST_OUTR;
                    end else begin
                        state_reg <= ST_SWPL;
                    end
                end
                ST_SWPL: begin
                    xi_reg    <= rd_x_reg;
                    yi_reg    <= rd_y_reg;
                    di_reg    <= deg_rd_reg;
                    j_reg     <= i_reg + 1'b1;
                    state_reg <= ST_SWPJ;
                end
                ST_SWPJ: begin
                    if (j_reg >= count_reg || dx > range_reg) begin
                        degs[i_reg[IdxW-1:0]] <= di_reg;
                        if (di_reg > dmax_reg) begin
                            dmax_reg <= di_reg;
                        end
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SWPI;
                    end else begin
                        state_reg <= ST_DIST;
                    end
                end
                ST_DIST: begin
                    if (dist_sq <= r2) begin
                        link_reg <= link_reg + 1'b1;
                        di_reg   <= di_reg + 1'b1;
                        degs[j_reg[IdxW-1:0]] <= deg_rd_reg + 1'b1;
                    end
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= ST_SWPJ;
                end
                ST_OUTR: begin
                    state_reg <= ST_OUTV;
                end
                ST_OUTV: begin
                    if (!m_valid) begin
                        m_valid        <= 1'b1;
                        m_sorted_x     <= rd_x_reg;
                        m_sorted_y     <= rd_y_reg;
                        m_point_degree <= deg_rd_reg;
                        m_link_total   <= link_reg;
                        m_max_degree   <= dmax_reg;
                        m_overflowed   <= ovf_reg;
                        m_last_result  <= (i_reg + 1'b1 == count_reg);
                    end else if (m_ready) begin
                        m_valid <= 1'b0;
                        if (m_last_result) begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_OUTR;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    `ASSERT_NEVER(a_ready_busy, s_ready && m_valid, "input open while results pending")
    `ASSERT_NEVER(a_count_cap, count_reg > CntW'(MaxPoints), "point count beyond store")
    `ASSERT_CLK(a_last_ends, (m_valid && m_ready && m_last_result) |=> s_ready,
                "block did not return to load after final beat")
endmodule
